/* hdl/sh3_pkg.sv */
`timescale 1ns / 1ps

package sh3_pkg;

  // width register as written by the configuration port
  localparam int unsigned CFG_BITS = 11;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd1024;

  // narrowest row that still holds an interior pixel
  localparam int unsigned MIN_WIDTH = 3;

  // rows needed above the current one before a window is complete
  localparam logic [1:0] ROWS_FULL = 2'd2;

  // first column whose window lies fully inside the row
  localparam int unsigned FIRST_INNER_COL = 2;

  typedef struct packed {
    logic emit;     // window is interior, a result follows
    logic last;     // last pixel of the input row
    logic restart;  // first pixel of a frame, window starts empty
  } item_tag_t;

endpackage

/* hdl/sh3_pos_ctrl.sv */
`timescale 1ns / 1ps

module sh3_pos_ctrl #(
  parameter int unsigned MAX_LINE = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sh3_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          advance,
  input  logic                          frame_start,
  output logic [$clog2(MAX_LINE)-1:0]   col,
  output sh3_pkg::item_tag_t            tag
);

  localparam int unsigned CW = $clog2(MAX_LINE);
  localparam int unsigned LW = $clog2(MAX_LINE + 1);

  logic [LW-1:0] width;
  logic [LW-1:0] width_next;
  logic [CW-1:0] column_pos;
  logic [1:0]    rows_seen;
  logic [1:0]    rows_cur;

  // clamp the written width once, at write time
  always_comb begin
    if (32'(cfg_data) < 32'(sh3_pkg::MIN_WIDTH)) begin
      width_next = LW'(sh3_pkg::MIN_WIDTH);
    end else if (32'(cfg_data) > 32'(MAX_LINE)) begin
      width_next = LW'(MAX_LINE);
    end else begin
      width_next = LW'(cfg_data);
    end
  end

  always_comb begin
    col      = frame_start ? '0 : column_pos;
    rows_cur = frame_start ? 2'd0 : rows_seen;
    tag.restart = frame_start;
    tag.last    = (32'(col) + 32'd1 >= 32'(width));
    tag.emit    = (rows_cur >= sh3_pkg::ROWS_FULL) &&
                  (32'(col) >= 32'(sh3_pkg::FIRST_INNER_COL));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width      <= LW'(32'(sh3_pkg::CFG_RESET) > 32'(MAX_LINE) ?
                       32'(MAX_LINE) : 32'(sh3_pkg::CFG_RESET));
      column_pos <= '0;
      rows_seen  <= 2'd0;
    end else begin
      if (cfg_write) begin
        width <= width_next;
      end
      if (advance) begin
        if (tag.last) begin
          column_pos <= '0;
          rows_seen  <= (rows_cur < sh3_pkg::ROWS_FULL) ? rows_cur + 2'd1 : rows_cur;
        end else begin
          column_pos <= col + CW'(1);
          rows_seen  <= rows_cur;
        end
      end
    end
  end

endmodule

/* hdl/sh3_line_buf.sv */
`timescale 1ns / 1ps

module sh3_line_buf #(
  parameter int unsigned MAX_LINE   = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_LINE)-1:0]  addr,
  input  logic [PIXEL_BITS-1:0]        pixel,
  input  logic                         hold_valid,
  output logic [PIXEL_BITS-1:0]        top,
  output logic [PIXEL_BITS-1:0]        mid
);

  localparam int unsigned CW = $clog2(MAX_LINE);

  logic [PIXEL_BITS-1:0] older_mem [MAX_LINE];
  logic [PIXEL_BITS-1:0] newer_mem [MAX_LINE];
  logic [PIXEL_BITS-1:0] older_q;
  logic [PIXEL_BITS-1:0] newer_q;
  logic [PIXEL_BITS-1:0] fwd_data;
  logic                  fwd;
  logic [CW-1:0]         addr_q;

  // newer row: read-first, the incoming pixel replaces the old entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      newer_q         <= newer_mem[addr];
      newer_mem[addr] <= pixel;
    end
  end

  // older row takes the entry read from the newer row in the cycle after the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      older_q <= older_mem[addr];
    end
    if (hold_valid) begin
      older_mem[addr_q] <= newer_q;
    end
  end

  // a read of the entry being written back this cycle sees the new value
  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_q   <= addr;
      fwd      <= hold_valid && (addr == addr_q);
      fwd_data <= newer_q;
    end
  end

  assign top = fwd ? fwd_data : older_q;
  assign mid = newer_q;

endmodule

/* hdl/sh3_kernel.sv */
`timescale 1ns / 1ps

module sh3_kernel #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic                          restart,
  input  logic [PIXEL_BITS-1:0]         top,
  input  logic [PIXEL_BITS-1:0]         mid,
  input  logic [PIXEL_BITS-1:0]         bot,
  output logic signed [PIXEL_BITS+4:0]  value
);

  localparam int unsigned OB = PIXEL_BITS + 5;

  // two previous columns, each top, middle, bottom
  logic [PIXEL_BITS-1:0] win [6];
  logic [OB-1:0]         centre9;
  logic [OB-1:0]         ring;

  always_comb begin
    centre9 = (OB'(win[4]) << 3) + OB'(win[4]);
    ring    = OB'(win[0]) + OB'(win[1]) + OB'(win[2]) + OB'(win[3]) +
              OB'(win[5]) + OB'(top) + OB'(mid) + OB'(bot);
    value   = signed'(centre9 - ring);
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win[0] <= restart ? '0 : win[3];
      win[1] <= restart ? '0 : win[4];
      win[2] <= restart ? '0 : win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= bot;
    end
  end

endmodule

/* hdl/sharpen_3x3_stream_top.sv */
`timescale 1ns / 1ps

// 3x3 sharpen filter on a raster stream of a bordered image. One pixel is taken
// per clock; results come out after their pixel passes the line store read and
// then the kernel sum into the result register; a request whose window is on the
// border yields no result. A stalled result side holds the pipeline, which then
// keeps taking pixels only as the result register frees. The width register
// (pixels per row with both border pixels) is clamped to 3..MAX_LINE and must be
// written while no pixel is in flight. The line stores hold MAX_LINE pixels each
// and need no clearing after reset.
module sharpen_3x3_stream_top #(
  parameter int unsigned MAX_LINE   = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sh3_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic [PIXEL_BITS-1:0]         pixel,
  input  logic                          frame_start,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [PIXEL_BITS+4:0]  sharpened,
  output logic                          row_last
);

  localparam int unsigned CW = $clog2(MAX_LINE);
  localparam int unsigned OB = PIXEL_BITS + 5;

  logic                  accept;
  logic                  out_free;
  logic                  b_adv;
  logic                  b_valid;
  sh3_pkg::item_tag_t    tag;
  sh3_pkg::item_tag_t    tag_b;
  logic [CW-1:0]         col;
  logic [PIXEL_BITS-1:0] pixel_b;
  logic [PIXEL_BITS-1:0] top;
  logic [PIXEL_BITS-1:0] mid;
  logic signed [OB-1:0]  value;

  assign cfg_ready   = 1'b1;
  assign out_free    = !result_valid || result_ready;
  assign b_adv       = b_valid && out_free;
  assign pixel_ready = !b_valid || out_free;
  assign accept      = pixel_valid && pixel_ready;

  sh3_pos_ctrl #(
    .MAX_LINE (MAX_LINE)
  ) u_pos_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .advance     (accept),
    .frame_start (frame_start),
    .col         (col),
    .tag         (tag)
  );

  sh3_line_buf #(
    .MAX_LINE   (MAX_LINE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_buf (
    .clk        (clk),
    .rd_en      (accept),
    .addr       (col),
    .pixel      (pixel),
    .hold_valid (b_valid),
    .top        (top),
    .mid        (mid)
  );

  sh3_kernel #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_kernel (
    .clk      (clk),
    .shift_en (b_adv),
    .restart  (tag_b.restart),
    .top      (top),
    .mid      (mid),
    .bot      (pixel_b),
    .value    (value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pixel_ready) begin
      b_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_b   <= tag;
      pixel_b <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= b_valid && tag_b.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && tag_b.emit) begin
      sharpened <= value;
      row_last  <= tag_b.last;
    end
  end

`ifndef SYNTHESIS
  // an interior window never starts in the first two columns
  a_emit_inner: assert property (@(posedge clk) disable iff (rst)
    accept && tag.emit |-> (32'(col) >= 32'(sh3_pkg::FIRST_INNER_COL)) && !tag.restart)
    else $error("result issued for a border column");

  // the request after the last pixel of a row starts at column zero
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && tag.last |=> (col == '0))
    else $error("column did not wrap after row end");

  // an interior request leaving the kernel stage shows up as a result
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    b_adv && tag_b.emit |=> result_valid)
    else $error("interior request lost");
`endif

endmodule
